/* rtl/time_ordered_event_queue_defines.svh */
// ---------------------------------------------------------------------------
// Time-ordered event queue: assertion macros
// Shared checks on the clk/rst domain of the queue.
// ---------------------------------------------------------------------------
`ifndef TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication
`define TOEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed");

// next-cycle implication
`define TOEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

/* rtl/toeq_pkg.sv */
// ---------------------------------------------------------------------------
// toeq_pkg
// Types and codes shared by the time-ordered event queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package toeq_pkg;

  localparam int TIME_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int SOURCE_W = 16;
  localparam int OCC_W    = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0]          time_v;
    logic signed [WEIGHT_W-1:0] weight;
    logic [SOURCE_W-1:0]        source;
  } entry_t;

  typedef struct packed {
    status_t                    status;
    logic [TIME_W-1:0]          time_v;
    logic signed [WEIGHT_W-1:0] weight;
    logic [SOURCE_W-1:0]        source;
    logic [OCC_W-1:0]           occupancy;
  } result_t;

endpackage

`default_nettype wire

/* rtl/toeq_mem.sv */
// ---------------------------------------------------------------------------
// toeq_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module toeq_mem #(
  parameter int RING_DEPTH = 64,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire toeq_pkg::entry_t wdata,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   raddr,
  output toeq_pkg::entry_t     rdata
);

  toeq_pkg::entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/toeq_ctrl.sv */
// ---------------------------------------------------------------------------
// toeq_ctrl
// Request sequencer: ring pointers, insertion shift walk and pop.
// ---------------------------------------------------------------------------
`default_nettype none

module toeq_ctrl #(
  parameter int RING_DEPTH = 64,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic [toeq_pkg::TIME_W-1:0]         event_time,
  input  wire logic signed [toeq_pkg::WEIGHT_W-1:0] event_weight,
  input  wire logic [toeq_pkg::SOURCE_W-1:0]       source_id,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output toeq_pkg::result_t                        res,
  output logic                                     mem_we,
  output logic [AW-1:0]                            mem_waddr,
  output toeq_pkg::entry_t                         mem_wdata,
  output logic                                     mem_rd_en,
  output logic [AW-1:0]                            mem_raddr,
  input  wire toeq_pkg::entry_t                    mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_POP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam logic [AW-1:0] LAST    = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_C = (AW+1)'(RING_DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  state_t                 state;
  logic [AW-1:0]          tail;
  logic [AW-1:0]          head;
  logic [AW-1:0]          idx;
  toeq_pkg::entry_t       ins;
  toeq_pkg::status_t      res_status;
  toeq_pkg::entry_t       res_entry;
  logic                   shift;
  logic [AW:0]            count;

  // keep moving up while the held entry is strictly later than the new one and the walk has not reached head
  assign shift = (idx != head) && (ins.time_v < mem_rdata.time_v);

  assign count = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                : ({1'b0, tail} + DEPTH_C - {1'b0, head});

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res = '{status:    res_status,
                 time_v:    res_entry.time_v,
                 weight:    res_entry.weight,
                 source:    res_entry.source,
                 occupancy: toeq_pkg::OCC_W'(count)};

  always_comb begin
    mem_rd_en = 1'b0;
    mem_raddr = tail;
    mem_we    = 1'b0;
    mem_waddr = ring_next(idx);
    mem_wdata = ins;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mem_rd_en = 1'b1;
          mem_raddr = (cmd == toeq_pkg::CMD_POP) ? ring_next(head) : tail;
        end
      end
      S_EVAL: begin
        mem_we = 1'b1;
        if (shift) begin
          mem_wdata = mem_rdata;
          mem_rd_en = 1'b1;
          mem_raddr = ring_prev(idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= '0;
      head  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_entry <= '0;
            if (cmd == toeq_pkg::CMD_POP) begin
              if (tail == head) begin
                res_status <= toeq_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                state <= S_POP;
              end
            end else if (ring_next(tail) == head) begin
              res_status <= toeq_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              ins   <= '{time_v: event_time, weight: event_weight, source: source_id};
              idx   <= tail;
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (shift) begin
            idx <= ring_prev(idx);
          end else begin
            tail       <= ring_next(tail);
            res_status <= toeq_pkg::ST_INSERTED;
            state      <= S_FIN;
          end
        end
        S_POP: begin
          res_entry  <= mem_rdata;
          head       <= ring_next(head);
          res_status <= toeq_pkg::ST_POPPED;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/time_ordered_event_queue.sv */
// Time-ordered event queue. Events are held in one entry RAM, sorted by time,
// earliest first; equal times keep arrival order. One request is worked at a
// time. An insert walks down from the tail, moving one later entry up a slot
// per cycle through the RAM's single read and single write port, once for
// each entry later than the new event (at most RING_DEPTH - 2 of them). A
// pop reads the earliest entry before its result; a refused insert or an
// empty pop goes straight to its result. The next request is taken the
// cycle after the result leaves the sequencer; a registered output stage
// holds it for the consumer. At most RING_DEPTH - 1 events are held.
// ---------------------------------------------------------------------------
// time_ordered_event_queue
// Sorted per-neuron event queue: insert in time order, pop earliest.
// ---------------------------------------------------------------------------
`default_nettype none

module time_ordered_event_queue #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 cmd,
  input  wire logic [toeq_pkg::TIME_W-1:0]          event_time,
  input  wire logic signed [toeq_pkg::WEIGHT_W-1:0] event_weight,
  input  wire logic [toeq_pkg::SOURCE_W-1:0]        source_id,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [1:0]                                status,
  output logic [toeq_pkg::TIME_W-1:0]               head_time,
  output logic signed [toeq_pkg::WEIGHT_W-1:0]      head_weight,
  output logic [toeq_pkg::SOURCE_W-1:0]             head_source,
  output logic [toeq_pkg::OCC_W-1:0]                occupancy
);

  localparam int AW = $clog2(RING_DEPTH);

  logic               res_valid;
  logic               res_ready;
  toeq_pkg::result_t  res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  toeq_pkg::entry_t   mem_wdata;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_raddr;
  toeq_pkg::entry_t   mem_rdata;

  toeq_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .event_time   (event_time),
    .event_weight (event_weight),
    .source_id    (source_id),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_rd_en    (mem_rd_en),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  toeq_mem #(.RING_DEPTH(RING_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rd_en (mem_rd_en),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      head_time   <= res.time_v;
      head_weight <= res.weight;
      head_source <= res.source;
      occupancy   <= res.occupancy;
    end
  end

`include "time_ordered_event_queue_defines.svh"

  `TOEQ_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)
  `TOEQ_ASSERT_NOW(a_zero_unless_popped,
      out_valid && (status != toeq_pkg::ST_POPPED),
      (head_time == '0) && (head_weight == '0) && (head_source == '0))
  `TOEQ_ASSERT_NOW(a_full_occupancy,
      out_valid && (status == toeq_pkg::ST_FULL),
      occupancy == toeq_pkg::OCC_W'(RING_DEPTH - 1))
  `TOEQ_ASSERT_NOW(a_empty_occupancy,
      out_valid && (status == toeq_pkg::ST_EMPTY), occupancy == '0)

endmodule

`default_nettype wire

/* tb/sv/toeq_scoreboard_pkg.sv */
// ---------------------------------------------------------------------------
// Event queue scoreboard
// Keeps a shadow copy of the sorted event ring and checks each response of
// the queue against the one predicted when its request was accepted.
// ---------------------------------------------------------------------------
package toeq_scoreboard_pkg;

  import toeq_pkg::*;

  localparam int QUEUE_SLOTS = 64;

  class event_queue_scoreboard;

    entry_t           ring_slot[QUEUE_SLOTS];
    logic [OCC_W-1:0] pop_ptr;    // slot before the earliest live entry
    logic [OCC_W-1:0] last_ptr;   // slot of the latest live entry
    result_t          awaited_responses[$];
    int               mismatches;
    int               checked;
    int               n_stored;
    int               n_refused;
    int               n_popped;
    int               n_empty;

    function new();
      pop_ptr    = '0;
      last_ptr   = '0;
      mismatches = 0;
      checked    = 0;
      n_stored   = 0;
      n_refused  = 0;
      n_popped   = 0;
      n_empty    = 0;
    endfunction

    // Work out the response to one accepted request and queue it.
    function void note_request(logic op, logic [TIME_W-1:0] t,
                               logic signed [WEIGHT_W-1:0] w, logic [SOURCE_W-1:0] s);
      result_t          resp;
      logic [OCC_W-1:0] walk;
      logic [OCC_W-1:0] above;
      resp = '0;
      if (op == CMD_INSERT) begin
        if (last_ptr + 6'd1 == pop_ptr) begin
          resp.status = ST_FULL;
          n_refused++;
        end else begin
          // shift later entries up one slot; equal times stay ahead of the new one
          walk = last_ptr;
          while (walk != pop_ptr && t < ring_slot[walk].time_v) begin
            above = walk + 6'd1;
            ring_slot[above] = ring_slot[walk];
            walk = walk - 6'd1;
          end
          above = walk + 6'd1;
          ring_slot[above].time_v = t;
          ring_slot[above].weight = w;
          ring_slot[above].source = s;
          last_ptr = last_ptr + 6'd1;
          resp.status = ST_INSERTED;
          n_stored++;
        end
      end else begin
        if (last_ptr == pop_ptr) begin
          resp.status = ST_EMPTY;
          n_empty++;
        end else begin
          pop_ptr = pop_ptr + 6'd1;
          resp.status = ST_POPPED;
          resp.time_v = ring_slot[pop_ptr].time_v;
          resp.weight = ring_slot[pop_ptr].weight;
          resp.source = ring_slot[pop_ptr].source;
          n_popped++;
        end
      end
      resp.occupancy = last_ptr - pop_ptr;
      awaited_responses.push_back(resp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got,
                                longint unsigned stamp);
      if (got !== want) begin
        $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", stamp, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got, longint unsigned stamp);
      result_t want;
      if (awaited_responses.size() == 0) begin
        $display("%0d ns: response with none expected, expected nothing, actual 0x%0h",
                 stamp, got);
        mismatches++;
        return;
      end
      want = awaited_responses.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status), stamp);
      compare_field("head_time", want.time_v, got.time_v, stamp);
      compare_field("head_weight", 32'(unsigned'(want.weight)), 32'(unsigned'(got.weight)),
                    stamp);
      compare_field("head_source", 32'(want.source), 32'(got.source), stamp);
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy), stamp);
    endfunction

    function void check_drained(longint unsigned stamp);
      if (awaited_responses.size() != 0) begin
        $display("%0d ns: responses missing, expected %0d more, actual 0",
                 stamp, awaited_responses.size());
        mismatches++;
      end
    endfunction

  endclass

endpackage

/* tb/sv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Drives insert and pop requests into the time-ordered event queue under
// several sender/receiver idle mixes and checks every response in order.
// ---------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import toeq_pkg::*;
  import toeq_scoreboard_pkg::*;

  localparam int RING_DEPTH   = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 358;
  localparam int SEGMENT_LEN  = 80;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       cmd = CMD_INSERT;
  logic [TIME_W-1:0]          event_time = '0;
  logic signed [WEIGHT_W-1:0] event_weight = '0;
  logic [SOURCE_W-1:0]        source_id = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 status;
  logic [TIME_W-1:0]          head_time;
  logic signed [WEIGHT_W-1:0] head_weight;
  logic [SOURCE_W-1:0]        head_source;
  logic [OCC_W-1:0]           occupancy;

  result_t observed;
  assign observed = {status, head_time, head_weight, head_source, occupancy};

  event_queue_scoreboard scoreboard = new();

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       cycle_count = 0;
  int unsigned       n_sent = 0;
  logic [TIME_W-1:0] tick_base = '0;

  time_ordered_event_queue #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .event_time   (event_time),
    .event_weight (event_weight),
    .source_id    (source_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .head_time    (head_time),
    .head_weight  (head_weight),
    .head_source  (head_source),
    .occupancy    (occupancy)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, scoreboard.awaited_responses.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      scoreboard.check_result(observed, $time);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic op, input logic [TIME_W-1:0] t,
                              input logic signed [WEIGHT_W-1:0] w,
                              input logic [SOURCE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    cmd          = op;
    event_time   = t;
    event_weight = w;
    source_id    = s;
    do @(posedge clk); while (in_ready !== 1'b1);
    scoreboard.note_request(op, t, w, s);
    n_sent++;
    @(negedge clk);
  endtask

  // Mix of wide random times, tight ties, values near the top, and a
  // mostly rising clock with some late arrivals.
  function automatic logic [TIME_W-1:0] pick_event_time();
    case ($urandom_range(4))
      0: return $urandom();
      1: return TIME_W'($urandom_range(15));
      2: return 32'hFFFF_FFF0 | TIME_W'($urandom_range(15));
      default: begin
        tick_base = tick_base + TIME_W'($urandom_range(8));
        return tick_base - TIME_W'($urandom_range(3));
      end
    endcase
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned insert_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    insert_pct     = 95;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // first segment fills the ring past full, then fill/drain/mixed at random
      if (i != 0 && i % SEGMENT_LEN == 0) begin
        case ($urandom_range(3))
          0: insert_pct = 95;
          1: insert_pct = 8;
          2: insert_pct = 55;
          default: insert_pct = 70;
        endcase
      end
      if ($urandom_range(99) < insert_pct)
        send_request(CMD_INSERT, pick_event_time(), pick_weight(), SOURCE_W'($urandom()));
      else
        send_request(CMD_POP, TIME_W'($urandom()), WEIGHT_W'($urandom()),
                     SOURCE_W'($urandom()));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty pop, field extremes, ties, earliest insert, drain
    send_request(CMD_POP, '0, '0, '0);
    send_request(CMD_INSERT, 32'd100, 16'sh0100, 16'd1);
    send_request(CMD_INSERT, 32'd100, -16'sd1, 16'd2);
    send_request(CMD_INSERT, 32'd50, 16'sh7FFF, 16'd3);
    send_request(CMD_INSERT, 32'd0, 16'sh8000, 16'h0000);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'sh0000, 16'hFFFF);
    send_request(CMD_INSERT, 32'd100, 16'sh0001, 16'd4);
    send_request(CMD_INSERT, 32'd75, 16'sh5A5A, 16'hA5A5);
    repeat (8) send_request(CMD_POP, 32'hFFFF_FFFF, 16'sh7FFF, 16'hFFFF);

    run_phase(0, 0);
    run_phase(54, 0);
    run_phase(0, 54);
    run_phase(11, 11);

    in_valid = 1'b0;
    while (scoreboard.awaited_responses.size() != 0) @(negedge clk);
    repeat (RING_DEPTH + 8) @(negedge clk);
    scoreboard.check_drained($time);

    $display("Sent %0d requests: %0d events stored, %0d refused on a full ring, %0d pops, %0d pops of an empty ring.",
             n_sent, scoreboard.n_stored, scoreboard.n_refused,
             scoreboard.n_popped, scoreboard.n_empty);
    $display("Idle mixes none/sender/receiver/both; %0d responses checked, %0d mismatches.",
             scoreboard.checked, scoreboard.mismatches);
    if (scoreboard.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
